// ===== hdl/dsrc_pkg.sv =====
// ----------------------------------------------------------------------------
// dsrc_pkg
// Shared types and constants of the dual slot record checker: slot layout,
// FNV-1a constants, status codes and register map.
// ----------------------------------------------------------------------------
package dsrc_pkg;

   localparam int SLOT_COUNT   = 2;
   localparam int SLOT_BYTES   = 28;
   localparam int HASHED_BYTES = 24;

   localparam int POS_W     = $clog2(SLOT_BYTES);
   localparam int SLOT_W    = $clog2(SLOT_COUNT + 1);
   localparam int BUF_DEPTH = SLOT_BYTES - 1;

   localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(SLOT_BYTES - 1);
   localparam logic [POS_W-1:0]  HASH_END  = POS_W'(HASHED_BYTES);
   localparam logic [SLOT_W-1:0] SLOT_MAX  = SLOT_W'(SLOT_COUNT);

   localparam logic [31:0] FNV_BASIS   = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME   = 32'd16777619;
   localparam logic [31:0] MAGIC_RESET = 32'h5250_5247;

   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] REG_EXPECTED_MAGIC = 1'b0;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_TRUNCATED  = 2'd1,
      STATUS_NONE_VALID = 2'd2
   } status_type;

endpackage

// ===== hdl/dsrc_req_if.sv =====
// ----------------------------------------------------------------------------
// dsrc_req_if
// Byte channel into the checker: one file byte and its last marker per item.
// ----------------------------------------------------------------------------
interface dsrc_req_if;

   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);

endinterface

// ===== hdl/dsrc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dsrc_rsp_if
// Result channel of the checker: status and the fields of the chosen slot.
// ----------------------------------------------------------------------------
interface dsrc_rsp_if import dsrc_pkg::*; ();

   logic        valid;
   logic        ready;
   status_type  status;
   logic [31:0] record_version;
   logic [63:0] applied_index;
   logic [63:0] sequence_number;
   logic [3:0]  chosen_slot;

   modport source (output valid, output status, output record_version,
                   output applied_index, output sequence_number,
                   output chosen_slot, input ready);
   modport sink   (input valid, input status, input record_version,
                   input applied_index, input sequence_number,
                   input chosen_slot, output ready);

endinterface

// ===== hdl/dual_slot_record_checker.sv =====
// ----------------------------------------------------------------------------
// dual_slot_record_checker
// Cuts a byte stream into 28-byte record slots, checks magic and FNV-1a
// checksum of each, and on the last byte reports a status and the valid slot
// with the highest sequence, the later slot on a tie.
//
//   channel   direction  handshake          payload
//   req_chan  in         valid/ready        data_byte, last_byte
//   rsp_chan  out        valid/ready        status, record_version,
//                                           applied_index, sequence_number,
//                                           chosen_slot
//   csr       in         apb (psel/penable) expected_magic at address 0
//
// one byte is accepted per cycle while no last byte waits for rsp_chan; a byte
// passes an input register and is then folded into the slot state, so a result
// passes the input register and the result register. the FNV multiply by the
// prime sets the cycle time. reset is synchronous, clears all control state and
// returns the magic register to its reset value. a result held by rsp_chan holds
// a following last byte in the input register, and with it all later bytes.
// ----------------------------------------------------------------------------
module dual_slot_record_checker import dsrc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   dsrc_req_if.sink              req_chan,
   dsrc_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [31:0]       hash_ff, hash_in;
   logic [7:0]        slot_bytes_ff [BUF_DEPTH];

   logic              best_found_ff, best_found_in;
   logic [63:0]       best_seq_ff, best_seq_in;
   logic [31:0]       best_ver_ff, best_ver_in;
   logic [63:0]       best_idx_ff, best_idx_in;
   logic [3:0]        best_slot_ff, best_slot_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   logic [31:0]       rsp_ver_ff;
   logic [63:0]       rsp_idx_ff;
   logic [63:0]       rsp_seq_ff;
   logic [3:0]        rsp_slot_ff;

   logic [31:0]       magic_ff;

   logic              advance;
   logic              take;
   logic              judge;
   logic              emit;
   logic [31:0]       hash_prod;
   logic [31:0]       slot_magic;
   logic [31:0]       slot_ver;
   logic [63:0]       slot_seq;
   logic [63:0]       slot_idx;
   logic [31:0]       slot_chk;
   logic              slot_ok;
   logic              slot_wins;
   status_type        status_in;

   // input stage
   assign advance        = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign in_valid_in    = (req_chan.valid && req_chan.ready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
         in_last_ff <= req_chan.last_byte;
      end
   end

   // slot assembly and judging
   assign take  = advance && (slot_ff < SLOT_MAX);
   assign judge = take && (pos_ff == LAST_POS);
   assign emit  = advance && in_last_ff;

   assign hash_prod  = (hash_ff ^ {24'd0, in_byte_ff}) * FNV_PRIME;
   assign slot_magic = {slot_bytes_ff[3], slot_bytes_ff[2], slot_bytes_ff[1], slot_bytes_ff[0]};
   assign slot_ver   = {slot_bytes_ff[7], slot_bytes_ff[6], slot_bytes_ff[5], slot_bytes_ff[4]};
   assign slot_seq   = {slot_bytes_ff[15], slot_bytes_ff[14], slot_bytes_ff[13],
                        slot_bytes_ff[12], slot_bytes_ff[11], slot_bytes_ff[10],
                        slot_bytes_ff[9], slot_bytes_ff[8]};
   assign slot_idx   = {slot_bytes_ff[23], slot_bytes_ff[22], slot_bytes_ff[21],
                        slot_bytes_ff[20], slot_bytes_ff[19], slot_bytes_ff[18],
                        slot_bytes_ff[17], slot_bytes_ff[16]};
   assign slot_chk   = {in_byte_ff, slot_bytes_ff[26], slot_bytes_ff[25], slot_bytes_ff[24]};
   assign slot_ok    = (slot_magic == magic_ff) && (slot_chk == hash_ff);
   assign slot_wins  = judge && slot_ok && (!best_found_ff || (slot_seq >= best_seq_ff));

   always_comb begin
      pos_in        = pos_ff;
      slot_in       = slot_ff;
      hash_in       = hash_ff;
      best_found_in = best_found_ff;
      best_seq_in   = best_seq_ff;
      best_ver_in   = best_ver_ff;
      best_idx_in   = best_idx_ff;
      best_slot_in  = best_slot_ff;
      if (take) begin
         pos_in = pos_ff + POS_W'(1);
         if (pos_ff < HASH_END) begin
            hash_in = hash_prod;
         end
      end
      if (judge) begin
         pos_in  = '0;
         slot_in = slot_ff + SLOT_W'(1);
         hash_in = FNV_BASIS;
      end
      if (slot_wins) begin
         best_found_in = 1'b1;
         best_seq_in   = slot_seq;
         best_ver_in   = slot_ver;
         best_idx_in   = slot_idx;
         best_slot_in  = 4'(slot_ff);
      end
   end

   always_comb begin
      if (slot_in == '0) begin
         status_in = STATUS_TRUNCATED;
      end else if (!best_found_in) begin
         status_in = STATUS_NONE_VALID;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         slot_ff       <= '0;
         hash_ff       <= FNV_BASIS;
         best_found_ff <= 1'b0;
      end else if (emit) begin
         pos_ff        <= '0;
         slot_ff       <= '0;
         hash_ff       <= FNV_BASIS;
         best_found_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         slot_ff       <= slot_in;
         hash_ff       <= hash_in;
         best_found_ff <= best_found_in;
      end
      best_seq_ff  <= best_seq_in;
      best_ver_ff  <= best_ver_in;
      best_idx_ff  <= best_idx_in;
      best_slot_ff <= best_slot_in;
      for (int i = 0; i < BUF_DEPTH; i++) begin
         if (take && (pos_ff == POS_W'(i))) begin
            slot_bytes_ff[i] <= in_byte_ff;
         end
      end
   end

   // result register
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_status_ff <= status_in;
         if (status_in == STATUS_OK) begin
            rsp_ver_ff  <= best_ver_in;
            rsp_idx_ff  <= best_idx_in;
            rsp_seq_ff  <= best_seq_in;
            rsp_slot_ff <= best_slot_in;
         end else begin
            rsp_ver_ff  <= '0;
            rsp_idx_ff  <= '0;
            rsp_seq_ff  <= '0;
            rsp_slot_ff <= '0;
         end
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.record_version  = rsp_ver_ff;
   assign rsp_chan.applied_index   = rsp_idx_ff;
   assign rsp_chan.sequence_number = rsp_seq_ff;
   assign rsp_chan.chosen_slot     = rsp_slot_ff;

   // register port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_EXPECTED_MAGIC) ? magic_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= MAGIC_RESET;
      end else if (psel && penable && pwrite && (paddr[2] == REG_EXPECTED_MAGIC)) begin
         magic_ff <= pwdata;
      end
   end

   // checks
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LAST_POS)
      else $error("slot byte position out of range");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_MAX)
      else $error("slot count beyond configured slots");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      emit |=> (pos_ff == '0) && (slot_ff == '0) && !best_found_ff && (hash_ff == FNV_BASIS))
      else $error("state not cleared after last byte");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STATUS_OK) |->
         (rsp_seq_ff == '0) && (rsp_idx_ff == '0) && (rsp_ver_ff == '0) && (rsp_slot_ff == '0))
      else $error("error result carries slot fields");

   a_chosen_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_OK) |-> (32'(rsp_slot_ff) < SLOT_COUNT))
      else $error("chosen slot beyond examined slots");

   a_emit_has_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> !rsp_valid_ff || rsp_chan.ready)
      else $error("result overwritten before taken");

endmodule
